// ===== sv/adtf_pkg.sv =====
`timescale 1ns / 1ps
// adtf_pkg: types, character codes and power-of-ten table for the
// ascii decimal to fixed point converter; no dependencies
package adtf_pkg;

    localparam int VALUE_W = 64;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_START,
        PH_WHOLE,
        PH_PART,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_PARSE,
        ST_INIT,
        ST_DIV,
        ST_EMIT
    } t_ctrl_state;

    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_status;

    function automatic logic [63:0] f_pow10(input logic [3:0] n);
        logic [63:0] p;
        unique case (n)
            4'd0:    p = 64'd1;
            4'd1:    p = 64'd10;
            4'd2:    p = 64'd100;
            4'd3:    p = 64'd1000;
            4'd4:    p = 64'd10000;
            4'd5:    p = 64'd100000;
            4'd6:    p = 64'd1000000;
            4'd7:    p = 64'd10000000;
            4'd8:    p = 64'd100000000;
            4'd9:    p = 64'd1000000000;
            4'd10:   p = 64'd10000000000;
            4'd11:   p = 64'd100000000000;
            4'd12:   p = 64'd1000000000000;
            4'd13:   p = 64'd10000000000000;
            4'd14:   p = 64'd100000000000000;
            default: p = 64'd1000000000000000;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/adtf_ctrl.sv =====
`timescale 1ns / 1ps
// adtf_ctrl: sequencing state machine for parse, fraction divide and emit
// depends on adtf_pkg
module adtf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    output logic                 o_in_stall,
    input  adtf_pkg::t_dp_status i_status,
    output adtf_pkg::t_dp_cmd    o_cmd
);
    import adtf_pkg::*;

    t_ctrl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_PARSE: begin
                if (i_in_valid && i_in_last) n_state = ST_INIT;
            end
            ST_INIT: n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_PARSE;
            end
            default: n_state = ST_PARSE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_PARSE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_INIT: o_cmd.div_init = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_EMIT: o_cmd.out_load = i_status.out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== sv/adtf_dp.sv =====
`timescale 1ns / 1ps
// adtf_dp: character parser registers, bit-serial fraction divider and
// output register; depends on adtf_pkg
module adtf_dp #(
    parameter int WHOLE_BITS      = 32,
    parameter int PART_BITS       = 32,
    parameter int MAX_PART_DIGITS = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  adtf_pkg::t_dp_cmd    i_cmd,
    output adtf_pkg::t_dp_status o_status,
    input  adtf_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output adtf_pkg::t_out_item  o_out_item
);
    import adtf_pkg::*;

    localparam int WA_W  = WHOLE_BITS - 1;
    localparam int DIG_W = $clog2(MAX_PART_DIGITS + 1);
    localparam int DEN_W = $clog2(f_pow10(4'(MAX_PART_DIGITS)) + 64'd1);
    localparam int CNT_W = $clog2(PART_BITS);

    // parser state
    t_phase             r_phase, n_phase;
    logic               r_negative, n_negative;
    logic [WA_W-1:0]    r_whole, n_whole;
    logic [DEN_W-1:0]   r_part, n_part;
    logic [DIG_W-1:0]   r_digits, n_digits;
    logic               r_clamp, n_clamp;

    // divider
    logic [DEN_W-1:0]     r_rem, r_den;
    logic [PART_BITS-1:0] r_q;
    logic [CNT_W-1:0]     r_cnt;
    logic [DEN_W:0]       rem_shift;
    logic                 rem_ge;

    logic       r_out_valid;
    t_out_item  r_out_item;

    logic              is_digit;
    logic [3:0]        digit;
    logic              whole_add;
    logic [WA_W+3:0]   whole_next;
    logic [DEN_W+3:0]  part_next;
    logic [VALUE_W-1:0] mag;

    assign is_digit = (i_in_item.ch >= CH_ZERO) && (i_in_item.ch <= CH_NINE);
    assign digit    = is_digit ? 4'(i_in_item.ch - CH_ZERO) : 4'd0;

    assign whole_next = ({3'b000, r_whole, 1'b0} + {1'b0, r_whole, 3'b000})
                      + (WA_W+4)'(digit);
    assign part_next  = ({3'b000, r_part, 1'b0} + {1'b0, r_part, 3'b000})
                      + (DEN_W+4)'(digit);

    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_whole    = r_whole;
        n_part     = r_part;
        n_digits   = r_digits;
        n_clamp    = r_clamp;
        whole_add  = 1'b0;
        unique case (r_phase)
            PH_START: begin
                if (i_in_item.ch == CH_MINUS) begin
                    n_negative = 1'b1;
                    n_phase    = PH_WHOLE;
                end else if (is_digit) begin
                    n_whole   = WA_W'(whole_next);
                    whole_add = 1'b1;
                    n_phase   = PH_WHOLE;
                end else if (i_in_item.ch == CH_POINT) begin
                    n_phase = PH_PART;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_WHOLE: begin
                if (is_digit) begin
                    n_whole   = WA_W'(whole_next);
                    whole_add = 1'b1;
                end else if (i_in_item.ch == CH_POINT) begin
                    n_phase = PH_PART;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_PART: begin
                if (is_digit) begin
                    if (r_digits < DIG_W'(MAX_PART_DIGITS)) begin
                        n_part   = DEN_W'(part_next);
                        n_digits = r_digits + 1'b1;
                    end
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: n_phase = PH_DONE;
        endcase
        // integer clamp
        if (whole_add && whole_next[WA_W+3:WA_W] != '0) begin
            n_whole = '1;
            n_clamp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_phase    <= PH_START;
            r_negative <= 1'b0;
            r_whole    <= '0;
            r_part     <= '0;
            r_digits   <= '0;
            r_clamp    <= 1'b0;
        end else if (i_cmd.accept) begin
            r_phase    <= n_phase;
            r_negative <= n_negative;
            r_whole    <= n_whole;
            r_part     <= n_part;
            r_digits   <= n_digits;
            r_clamp    <= n_clamp;
        end
    end

    // restoring division, one quotient bit per cycle
    assign rem_shift = {r_rem, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= r_part;
            r_den <= DEN_W'(f_pow10(4'(r_digits)));
            r_q   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? DEN_W'(rem_shift - {1'b0, r_den}) : DEN_W'(rem_shift);
            r_q   <= {r_q[PART_BITS-2:0], rem_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign mag = (VALUE_W'(r_whole) << PART_BITS) | VALUE_W'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.value     <= r_negative ? -mag : mag;
            r_out_item.saturated <= r_clamp;
        end
    end

    assign o_status.div_last = (r_cnt == CNT_W'(PART_BITS - 1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");
    a_digits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits <= DIG_W'(MAX_PART_DIGITS))
        else $error("fraction digit count over limit");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten");
    a_load_clears_parser: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_out_valid && r_phase == PH_START && r_digits == '0))
        else $error("result load did not restart parser");
    a_accept_not_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> !i_cmd.div_step && !i_cmd.div_init)
        else $error("character taken during fraction divide");

endmodule

// ===== sv/ascii_decimal_to_fixed_point.sv =====
`timescale 1ns / 1ps
// ascii_decimal_to_fixed_point: top level joining controller and datapath
// depends on adtf_pkg, adtf_ctrl, adtf_dp
// Characters are taken one per cycle while o_in_stall is low. After a
// character marked last the converter sets up the divider, runs PART_BITS
// steps of the one-bit-per-cycle restoring divider that scales the fraction
// by the power-of-ten reciprocal, then loads the result, first waiting while
// the output register is stalled with an earlier transaction still in it.
// No clearing pass is needed after reset.
module ascii_decimal_to_fixed_point #(
    parameter int WHOLE_BITS      = 32,
    parameter int PART_BITS       = 32,
    parameter int MAX_PART_DIGITS = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  adtf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output adtf_pkg::t_out_item o_out_item
);
    import adtf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    adtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_item.last),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    adtf_dp #(
        .WHOLE_BITS      (WHOLE_BITS),
        .PART_BITS       (PART_BITS),
        .MAX_PART_DIGITS (MAX_PART_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
